// ----- rtl/nor_flash_command_decoder_core_macros.svh -----
// Assertion helpers used by the command decoder core.
`ifndef NOR_FLASH_COMMAND_DECODER_CORE_MACROS_SVH
`define NOR_FLASH_COMMAND_DECODER_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define NFCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define NFCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/nfcd_pkg.sv -----
// ----------------------------------------------------------------------------
// nfcd_pkg
// Types and constants of the NOR flash command decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nfcd_pkg;

   localparam int ADDR_BITS_DEFAULT = 25;
   localparam int CSR_DATA_BITS     = 32;
   localparam int CSR_INDEX_BITS    = 2;

   // Command-cycle address compare covers offset bits 11:1
   localparam int CMD_LSB = 1;
   localparam int CMD_MSB = 11;

   // Sector size limits (log2 bytes)
   localparam logic [4:0] SECTOR_LOG2_MIN = 5'd12;
   localparam logic [4:0] SECTOR_LOG2_MAX = 5'd24;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNLOCK_FIRST  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNLOCK_SECOND = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AUTO_IDENT    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECTOR_LOG2   = 2'd3;

   // Register reset values
   localparam logic [24:0] UNLOCK_FIRST_RESET  = 25'h0000AAA;
   localparam logic [24:0] UNLOCK_SECOND_RESET = 25'h0000554;
   localparam logic [31:0] AUTO_IDENT_RESET    = 32'h0000_0000;
   localparam logic [4:0]  SECTOR_LOG2_RESET   = 5'd17;

   // Command codes (low byte of the written halfword)
   localparam logic [7:0] CMD_UNLOCK1     = 8'hAA;
   localparam logic [7:0] CMD_UNLOCK2     = 8'h55;
   localparam logic [7:0] CMD_AUTOSELECT  = 8'h90;
   localparam logic [7:0] CMD_PROGRAM     = 8'hA0;
   localparam logic [7:0] CMD_ERASE_SETUP = 8'h80;
   localparam logic [7:0] CMD_BYPASS      = 8'h20;
   localparam logic [7:0] CMD_RESET       = 8'hF0;
   localparam logic [7:0] CMD_ERASE_SECT  = 8'h30;
   localparam logic [7:0] CMD_ERASE_CHIP  = 8'h10;
   localparam logic [7:0] CMD_BYPASS_EXIT = 8'h00;

   typedef enum logic [3:0] {
      ST_READ   = 4'd0,
      ST_UNL1   = 4'd1,
      ST_UNL2   = 4'd2,
      ST_PROG   = 4'd3,
      ST_ESETUP = 4'd4,
      ST_EUNL1  = 4'd5,
      ST_EUNL2  = 4'd6,
      ST_AUTO   = 4'd7,
      ST_BPROG  = 4'd8,
      ST_BEXIT  = 4'd9
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_PROG   = 3'd1,
      ACT_ESECT  = 3'd2,
      ACT_ECHIP  = 3'd3,
      ACT_AENTER = 3'd4,
      ACT_ALEAVE = 3'd5
   } action_type;

   // Configuration as the decoder sees it
   typedef struct packed {
      logic [CMD_MSB:CMD_LSB] unlock_first;
      logic [CMD_MSB:CMD_LSB] unlock_second;
      logic [31:0]            auto_ident;
      logic [4:0]             sector_log2;
   } cfg_type;

   // Decoder control result for one transfer
   typedef struct packed {
      state_type  next_state;
      logic       next_bypass;
      action_type action;
   } ctrl_type;

endpackage

// ----- rtl/nor_flash_command_decoder_core.sv -----
// ----------------------------------------------------------------------------
// nor_flash_command_decoder_core
// NOR flash command-set decoder: one bus write in, one array action out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one halfword bus write (byte offset and value) per transfer.
//   rsp_*  carries one action per write: none, program, erase sector (with
//          aligned base), erase chip, enter or leave autoselect, and the
//          bypass flag after that write.
//   csr_*  writes the unlock addresses, the autoselect ident word and the
//          sector size; write only while no transfer is in flight.
// Path: a request passes the input register, then the result register, before
//   its result is presented; a stall can hold it in either register.
// Throughput: one write per cycle unless the result stalls; the command
//   state updates in the same cycle the decode lands in the result register.
// Reset: command state returns to read array, bypass clears, registers take
//   their default values, both stages empty.
// Stall: while rsp_ready is low the result holds; one more write is taken
//   into the input register, after which req_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nor_flash_command_decoder_core #(
   parameter int ADDR_BITS = nfcd_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ADDR_BITS-1:0]                req_write_offset,
   input  logic [15:0]                         req_write_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_action,
   output logic [ADDR_BITS-1:0]                rsp_target_offset,
   output logic [31:0]                         rsp_payload,
   output logic                                rsp_bypass_active,
   input  logic                                csr_wen,
   input  logic [nfcd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [nfcd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import nfcd_pkg::*;

   `include "nor_flash_command_decoder_core_macros.svh"

   cfg_type              cfg_ff;
   logic                 s1_valid_ff;
   logic [ADDR_BITS-1:0] s1_offset_ff;
   logic [15:0]          s1_value_ff;
   state_type            state_ff;
   logic                 bypass_ff;
   logic                 out_valid_ff;
   action_type           out_action_ff;
   logic [ADDR_BITS-1:0] out_target_ff;
   logic [31:0]          out_payload_ff;
   logic                 out_bypass_ff;

   ctrl_type             ctrl_in;
   logic [ADDR_BITS-1:0] target_in;
   logic [31:0]          payload_in;
   logic                 out_load;
   logic                 s1_load;

   // Stage advance
   assign out_load  = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || out_load;
   assign s1_load   = req_valid && req_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.unlock_first  <= UNLOCK_FIRST_RESET[CMD_MSB:CMD_LSB];
         cfg_ff.unlock_second <= UNLOCK_SECOND_RESET[CMD_MSB:CMD_LSB];
         cfg_ff.auto_ident    <= AUTO_IDENT_RESET;
         cfg_ff.sector_log2   <= SECTOR_LOG2_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_UNLOCK_FIRST:  cfg_ff.unlock_first  <= csr_wdata[CMD_MSB:CMD_LSB];
            CSR_UNLOCK_SECOND: cfg_ff.unlock_second <= csr_wdata[CMD_MSB:CMD_LSB];
            CSR_AUTO_IDENT:    cfg_ff.auto_ident    <= csr_wdata;
            CSR_SECTOR_LOG2:   cfg_ff.sector_log2   <= csr_wdata[4:0];
            default:           cfg_ff.sector_log2   <= cfg_ff.sector_log2;
         endcase
      end
   end

   // Input register: capture the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_offset_ff <= req_write_offset;
         s1_value_ff  <= req_write_value;
      end
   end

   nfcd_decode #(
      .ADDR_BITS (ADDR_BITS)
   ) u_decode (
      .state         (state_ff),
      .bypass        (bypass_ff),
      .cfg           (cfg_ff),
      .write_offset  (s1_offset_ff),
      .write_value   (s1_value_ff),
      .ctrl          (ctrl_in),
      .target_offset (target_in),
      .payload       (payload_in)
   );

   // Command state: advance as each decode lands in the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_READ;
         bypass_ff <= 1'b0;
      end else if (out_load) begin
         state_ff  <= ctrl_in.next_state;
         bypass_ff <= ctrl_in.next_bypass;
      end
   end

   // Result register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_action_ff  <= ctrl_in.action;
         out_target_ff  <= target_in;
         out_payload_ff <= payload_in;
         out_bypass_ff  <= ctrl_in.next_bypass;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_action        = 3'(out_action_ff);
   assign rsp_target_offset = out_target_ff;
   assign rsp_payload       = out_payload_ff;
   assign rsp_bypass_active = out_bypass_ff;

   // Unlock and command sequences run only outside bypass mode
   `NFCD_ASSERT(a_seq_no_bypass, clock, reset,
      !((state_ff == ST_UNL1 || state_ff == ST_UNL2 || state_ff == ST_PROG ||
         state_ff == ST_ESETUP || state_ff == ST_EUNL1 || state_ff == ST_EUNL2 ||
         state_ff == ST_AUTO) && bypass_ff), "command sequence active in bypass mode")
   // Bypass program and exit states only arise in bypass mode
   `NFCD_ASSERT(a_bypass_states, clock, reset,
      !((state_ff == ST_BPROG || state_ff == ST_BEXIT) && !bypass_ff),
      "bypass state without bypass mode")
   // Target offset is zero unless program or sector erase
   `NFCD_ASSERT(a_target_zero, clock, reset,
      !(rsp_valid && out_action_ff != ACT_PROG && out_action_ff != ACT_ESECT &&
        rsp_target_offset != '0), "nonzero target offset on non-addressed action")
   // Sector base is aligned to at least the minimum sector size
   `NFCD_ASSERT(a_sector_aligned, clock, reset,
      !(rsp_valid && out_action_ff == ACT_ESECT && rsp_target_offset[11:0] != 12'h000),
      "sector erase base not aligned")
   // A decode that moves forward is presented in the next cycle
   `NFCD_ASSERT_NEXT(a_out_follows, clock, reset, out_load, rsp_valid,
      "decoded transfer not presented")

endmodule

// ----- rtl/nfcd_decode.sv -----
// ----------------------------------------------------------------------------
// nfcd_decode
// Command state transition and action decode for one bus write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfcd_decode #(
   parameter int ADDR_BITS = nfcd_pkg::ADDR_BITS_DEFAULT
) (
   input  nfcd_pkg::state_type state,
   input  logic                bypass,
   input  nfcd_pkg::cfg_type   cfg,
   input  logic [ADDR_BITS-1:0] write_offset,
   input  logic [15:0]          write_value,
   output nfcd_pkg::ctrl_type  ctrl,
   output logic [ADDR_BITS-1:0] target_offset,
   output logic [31:0]          payload
);
   import nfcd_pkg::*;

   logic [7:0]             code;
   logic [CMD_MSB:CMD_LSB] cmd_off;
   logic                   hit_first;
   logic                   hit_second;
   logic [4:0]             sect_log2;
   logic [ADDR_BITS-1:0]   sect_mask;
   state_type              nxt_state;
   logic                   nxt_bypass;
   action_type             act;

   assign code       = write_value[7:0];
   assign cmd_off    = write_offset[CMD_MSB:CMD_LSB];
   assign hit_first  = (cmd_off == cfg.unlock_first);
   assign hit_second = (cmd_off == cfg.unlock_second);

   // Clamp sector size and build the base alignment mask
   always_comb begin
      if (cfg.sector_log2 < SECTOR_LOG2_MIN) begin
         sect_log2 = SECTOR_LOG2_MIN;
      end else if (cfg.sector_log2 > SECTOR_LOG2_MAX) begin
         sect_log2 = SECTOR_LOG2_MAX;
      end else begin
         sect_log2 = cfg.sector_log2;
      end
      sect_mask = {ADDR_BITS{1'b1}} << sect_log2;
   end

   // Next state and bypass flag
   always_comb begin
      nxt_state  = ST_READ;
      nxt_bypass = bypass;
      unique case (state)
         ST_UNL1: begin
            if (code == CMD_UNLOCK2 && hit_second) nxt_state = ST_UNL2;
         end
         ST_UNL2: begin
            if (hit_first) begin
               case (code)
                  CMD_AUTOSELECT:  nxt_state  = ST_AUTO;
                  CMD_PROGRAM:     nxt_state  = ST_PROG;
                  CMD_ERASE_SETUP: nxt_state  = ST_ESETUP;
                  CMD_BYPASS:      nxt_bypass = 1'b1;
                  default:         nxt_state  = ST_READ;
               endcase
            end
         end
         ST_PROG, ST_BPROG: begin
            nxt_state = ST_READ;
         end
         ST_ESETUP: begin
            if (code == CMD_UNLOCK1 && hit_first) nxt_state = ST_EUNL1;
         end
         ST_EUNL1: begin
            if (code == CMD_UNLOCK2 && hit_second) nxt_state = ST_EUNL2;
         end
         ST_EUNL2: begin
            nxt_state = ST_READ;
         end
         ST_AUTO: begin
            if (code != CMD_RESET) nxt_state = ST_AUTO;
         end
         ST_BEXIT: begin
            if (code == CMD_BYPASS_EXIT) nxt_bypass = 1'b0;
         end
         default: begin
            // read state, and any unused code behaves the same
            if (bypass) begin
               if (code == CMD_PROGRAM) begin
                  nxt_state = ST_BPROG;
               end else if (code == CMD_AUTOSELECT) begin
                  nxt_state = ST_BEXIT;
               end
            end else if (code == CMD_UNLOCK1 && hit_first) begin
               nxt_state = ST_UNL1;
            end
         end
      endcase
   end

   // Action, target and payload
   always_comb begin
      act           = ACT_NONE;
      target_offset = '0;
      payload       = '0;
      unique case (state)
         ST_UNL2: begin
            if (hit_first && code == CMD_AUTOSELECT) begin
               act     = ACT_AENTER;
               payload = cfg.auto_ident;
            end
         end
         ST_PROG, ST_BPROG: begin
            act           = ACT_PROG;
            target_offset = write_offset;
            payload       = {16'h0000, write_value};
         end
         ST_EUNL2: begin
            if (code == CMD_ERASE_SECT) begin
               act           = ACT_ESECT;
               target_offset = write_offset & sect_mask;
            end else if (code == CMD_ERASE_CHIP) begin
               act = ACT_ECHIP;
            end
         end
         ST_AUTO: begin
            if (code == CMD_RESET) act = ACT_ALEAVE;
         end
         default: begin
            act = ACT_NONE;
         end
      endcase
   end

   assign ctrl = '{next_state: nxt_state, next_bypass: nxt_bypass, action: act};

endmodule
